@@ src/ffha_pkg.sv @@
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

	// heap geometry
	localparam int HEAP_BYTES = 4096;
	localparam int SLOT_BYTES = 16;
	localparam int HDR_BYTES  = 8;
	localparam int SLOTS      = HEAP_BYTES / SLOT_BYTES;
	localparam int SLOT_W     = $clog2(SLOTS);

	// header word and field widths
	localparam int WORD_W = 14;
	localparam int REQ_W  = 16;
	localparam int OFF_W  = 12;
	localparam int NEED_W = REQ_W + 1;

	// width of the next-slot sum of the list walk
	localparam int NXT_W = ((WORD_W - 4 > SLOT_W) ? WORD_W - 4 : SLOT_W) + 1;

	// header word values
	localparam logic [WORD_W-1:0] END_WORD  = WORD_W'(1);
	localparam logic [WORD_W-1:0] INIT_WORD = WORD_W'(HEAP_BYTES - SLOT_BYTES);

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
	localparam logic [1:0] STATUS_BAD_PTR = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [REQ_W-1:0]  request_bytes;
		logic [OFF_W-1:0]  user_offset;
	} ffha_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [OFF_W-1:0]  payload_offset;
	} ffha_rsp_t;

endpackage

@@ src/ffha_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/first_fit_heap_allocator_core.sv @@
// first-fit heap allocator: header ram, list walker and response register
//
// The heap is cut into 16-byte slots, and each block's header word (size
// with the allocated flag in bit 0) lives in a 256-entry header ram, one
// entry per slot. After reset the block runs a clearing pass over every
// slot that writes the initial heap (one free block, then the end header)
// and holds req_stall high meanwhile. Each request walks the header list
// one header at a time, since the header ram has one registered read port
// and the next header's slot is known only after the current one is read.
// An allocate reads and checks each visited header and, on a fit, writes
// the allocated header and any split remainder; a free reads and checks
// each visited header and, on a match, merges with free neighbours.
// One request is in work at a time; the next request is taken right after
// the previous result is handed to the output register, and its own result
// waits in the sequencer until that register has room.
module first_fit_heap_allocator_core import ffha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  ffha_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output ffha_rsp_t rsp
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_A_WHDR,
		ST_F_RD,
		ST_F_CHK,
		ST_F_ARD,
		ST_F_ACHK,
		ST_F_WFND,
		ST_F_WPRV,
		ST_RESP
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [SLOT_W-1:0]   p_q;
	logic [SLOT_W-1:0]   found_q;
	logic [SLOT_W-1:0]   prev_q;
	logic                prev_vld_q;
	logic [WORD_W-1:0]   prev_w_q;
	logic [WORD_W-1:0]   fword_q;
	logic [NEED_W-1:0]   need_q;
	logic [OFF_W-1:0]    uoff_q;
	ffha_rsp_t           res_q;
	ffha_rsp_t           rsp_q;
	logic                rsp_valid_q;

	logic                we;
	logic [SLOT_W-1:0]   waddr;
	logic [WORD_W-1:0]   wdata;
	logic [WORD_W-1:0]   hdr_rdata;

	logic [NXT_W-1:0]    nxt_sum;
	logic                nxt_end;
	logic                is_end;
	logic                fits;
	logic [WORD_W-1:0]   rem;
	logic                do_split;
	logic [OFF_W-1:0]    slot_off;
	logic [NEED_W-1:0]   need_calc;

	// header store
	ffha_ram #(
		.WIDTH(WORD_W),
		.DEPTH(SLOTS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(p_q),
		.rdata(hdr_rdata)
	);

	// next slot of the walk and end detection
	assign nxt_sum  = NXT_W'(p_q) + NXT_W'(hdr_rdata[WORD_W-1:4]);
	assign nxt_end  = (hdr_rdata[WORD_W-1:1] == '0) || (nxt_sum >= NXT_W'(SLOTS));
	assign is_end   = (hdr_rdata == END_WORD);

	// fit test and split remainder for allocate
	assign fits     = !hdr_rdata[0] && (NEED_W'(hdr_rdata) >= need_q);
	assign rem      = hdr_rdata - need_q[WORD_W-1:0];
	assign do_split = (rem[WORD_W-1:4] != '0);
	assign slot_off = OFF_W'({p_q, 4'(HDR_BYTES)});

	// rounded block size of an allocate
	assign need_calc = (NEED_W'(req.request_bytes) + NEED_W'(HDR_BYTES + SLOT_BYTES - 1))
		& ~NEED_W'(SLOT_BYTES - 1);

	// header ram writes
	always_comb begin
		we    = 1'b0;
		waddr = p_q;
		wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				if (clr_q == '0) begin
					wdata = INIT_WORD;
				end else if (clr_q == SLOT_W'(SLOTS - 1)) begin
					wdata = END_WORD;
				end
			end
			ST_A_CHK: begin
				if (fits) begin
					we = 1'b1;
					if (do_split) begin
						waddr = p_q + need_q[SLOT_W+3:4];
						wdata = rem;
					end else begin
						wdata = hdr_rdata | WORD_W'(1);
					end
				end
			end
			ST_A_WHDR: begin
				we    = 1'b1;
				wdata = need_q[WORD_W-1:0] | WORD_W'(1);
			end
			ST_F_WFND: begin
				we    = 1'b1;
				waddr = found_q;
				wdata = fword_q;
			end
			ST_F_WPRV: begin
				we    = 1'b1;
				waddr = prev_q;
				wdata = prev_w_q + fword_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			p_q         <= '0;
			prev_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						p_q        <= '0;
						prev_vld_q <= 1'b0;
						need_q     <= need_calc;
						uoff_q     <= req.user_offset;
						if (req.cmd == CMD_FREE) begin
							state_q <= ST_F_RD;
						end else if (req.request_bytes == '0) begin
							res_q.status         <= STATUS_NO_FIT;
							res_q.payload_offset <= '0;
							state_q              <= ST_RESP;
						end else begin
							state_q <= ST_A_RD;
						end
					end
				end
				ST_A_RD: begin
					state_q <= ST_A_CHK;
				end
				ST_A_CHK: begin
					if (is_end) begin
						res_q.status         <= STATUS_NO_FIT;
						res_q.payload_offset <= '0;
						state_q              <= ST_RESP;
					end else if (fits) begin
						res_q.status         <= STATUS_OK;
						res_q.payload_offset <= slot_off;
						state_q              <= do_split ? ST_A_WHDR : ST_RESP;
					end else if (nxt_end) begin
						res_q.status         <= STATUS_NO_FIT;
						res_q.payload_offset <= '0;
						state_q              <= ST_RESP;
					end else begin
						p_q     <= nxt_sum[SLOT_W-1:0];
						state_q <= ST_A_RD;
					end
				end
				ST_A_WHDR: begin
					state_q <= ST_RESP;
				end
				ST_F_RD: begin
					state_q <= ST_F_CHK;
				end
				ST_F_CHK: begin
					if (is_end) begin
						res_q.status         <= STATUS_BAD_PTR;
						res_q.payload_offset <= '0;
						state_q              <= ST_RESP;
					end else if (hdr_rdata[0] && (slot_off == uoff_q)) begin
						found_q <= p_q;
						fword_q <= hdr_rdata & ~WORD_W'(1);
						if (nxt_end) begin
							state_q <= ST_F_WFND;
						end else begin
							p_q     <= nxt_sum[SLOT_W-1:0];
							state_q <= ST_F_ARD;
						end
					end else begin
						prev_q     <= p_q;
						prev_w_q   <= hdr_rdata;
						prev_vld_q <= 1'b1;
						if (nxt_end) begin
							res_q.status         <= STATUS_BAD_PTR;
							res_q.payload_offset <= '0;
							state_q              <= ST_RESP;
						end else begin
							p_q     <= nxt_sum[SLOT_W-1:0];
							state_q <= ST_F_RD;
						end
					end
				end
				ST_F_ARD: begin
					state_q <= ST_F_ACHK;
				end
				ST_F_ACHK: begin
					// merge with a free block after it
					if (!hdr_rdata[0] && (hdr_rdata != '0)) begin
						fword_q <= fword_q + hdr_rdata;
					end
					state_q <= ST_F_WFND;
				end
				ST_F_WFND: begin
					res_q.status         <= STATUS_OK;
					res_q.payload_offset <= '0;
					// merge into a free block before it
					if (prev_vld_q && !prev_w_q[0]) begin
						state_q <= ST_F_WPRV;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_F_WPRV: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted item keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != ST_IDLE))
		else $error("block idle right after accepting an item");

	// no header write while idle
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !we)
		else $error("header write while idle");

	// a failure carries a zero offset
	a_fail_zero_off: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status != STATUS_OK)) |-> (rsp.payload_offset == '0))
		else $error("failed item with nonzero offset");

	// a nonzero offset is a successful allocate on a slot boundary plus header
	a_off_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.payload_offset != '0))
		|-> ((rsp.status == STATUS_OK) && (rsp.payload_offset[3:0] == 4'(HDR_BYTES))))
		else $error("payload offset not aligned to a block");

	// the block before a freed block lies below it
	a_prev_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_WPRV) |-> (prev_q < found_q))
		else $error("merge target not before freed block");

endmodule
